/* rtl/acsc_pkg.sv */
// ----------------------------------------------------------------------------
// acsc_pkg
// Shared constants and types for the clip-space box cull pipeline.
// ----------------------------------------------------------------------------
package acsc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 68;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_BOX  = 1'b1;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

endpackage

/* rtl/aabb_clip_space_cull.sv */
// Latency: a box request passes the stage 1 to stage 4 registers and shows its result on out_visible from stage 5.
// Throughput: one request per cycle while out_stall does not back up the pipeline; a matrix load gives no result.
// The rate is set by the five-deep register pipeline through the 24 multipliers.
// Reset clears all valid bits; the matrix is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// aabb_clip_space_cull
// Culls an axis-aligned box against the clip-space frustum. The box is split
// into its centre and half-size terms, each row of the matrix is applied to
// both, and the extreme corner against each plane is found from absolute
// values of the half-size terms.
// ----------------------------------------------------------------------------
module aabb_clip_space_cull
  import acsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [3:0]         in_elem_index,
  input  logic signed [31:0] in_elem_value,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic [30:0]        in_half_x,
  input  logic [30:0]        in_half_y,
  input  logic [30:0]        in_half_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_visible
);

  logic [31:0] mat_r [16];

  logic               v1_r;
  logic               s1_kind_r;
  logic [3:0]         s1_idx_r;
  logic [31:0]        s1_val_r;
  logic signed [31:0] s1_ctr_r  [3];
  logic [30:0]        s1_half_r [3];

  logic  v2_r;
  prod_t prc_r [4][3];
  prod_t prh_r [4][3];
  prod_t prc_nxt [4][3];
  prod_t prh_nxt [4][3];
  logic signed [31:0] m3_r [4];

  logic v3_r;
  acc_t base_r [4];
  acc_t dsum_r [3][3];
  acc_t ddif_r [3][3];
  acc_t base_nxt [4];
  acc_t dsum_nxt [3][3];
  acc_t ddif_nxt [3][3];

  logic v4_r;
  acc_t p_r [3];
  acc_t q_r [3];
  acc_t dabs_r [3][3];
  acc_t eabs_r [3][3];
  acc_t p_nxt [3];
  acc_t q_nxt [3];
  acc_t dabs_nxt [3][3];
  acc_t eabs_nxt [3][3];

  logic out_valid_r;
  logic visible_r;
  logic visible_nxt;
  acc_t below_sum [3];
  acc_t above_sum [3];

  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !out_valid_r || !out_stall;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || (s1_kind_r == KIND_LOAD) || adv2;

  assign in_stall    = !adv1;
  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_kind_r    <= in_kind;
      s1_idx_r     <= in_elem_index;
      s1_val_r     <= in_elem_value;
      s1_ctr_r[0]  <= in_center_x;
      s1_ctr_r[1]  <= in_center_y;
      s1_ctr_r[2]  <= in_center_z;
      s1_half_r[0] <= in_half_x;
      s1_half_r[1] <= in_half_y;
      s1_half_r[2] <= in_half_z;
    end
  end

  // A load is written as it leaves stage 1, so later boxes see it and earlier ones do not.
  always_ff @(posedge clk) begin
    if (v1_r && s1_kind_r == KIND_LOAD) begin
      mat_r[s1_idx_r] <= s1_val_r;
    end
  end

  // Stage 2: row-by-column products of the centre and the half sizes.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prc_nxt[r][c] = signed'(mat_r[4'(r * 4 + c)]) * s1_ctr_r[c];
        prh_nxt[r][c] = signed'(mat_r[4'(r * 4 + c)]) * signed'({1'b0, s1_half_r[c]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r && (s1_kind_r == KIND_BOX);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      prc_r <= prc_nxt;
      prh_r <= prh_nxt;
      for (int r = 0; r < 4; r++) begin
        m3_r[r] <= signed'(mat_r[4'(r * 4 + 3)]);
      end
    end
  end

  // Stage 3: centre term of each row, and the half-size terms against each plane.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      base_nxt[r] = ACC_W'(prc_r[r][0]) + ACC_W'(prc_r[r][1]) + ACC_W'(prc_r[r][2])
                  + (ACC_W'(m3_r[r]) <<< FRAC_BITS);
    end
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        dsum_nxt[a][c] = ACC_W'(prh_r[3][c]) + ACC_W'(prh_r[a][c]);
        ddif_nxt[a][c] = ACC_W'(prh_r[3][c]) - ACC_W'(prh_r[a][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      base_r <= base_nxt;
      dsum_r <= dsum_nxt;
      ddif_r <= ddif_nxt;
    end
  end

  // Stage 4: plane offsets of the centre and magnitudes of the half-size terms.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p_nxt[a] = base_r[a] + base_r[3];
      q_nxt[a] = base_r[3] - base_r[a];
      for (int c = 0; c < 3; c++) begin
        dabs_nxt[a][c] = dsum_r[a][c][ACC_W-1] ? -dsum_r[a][c] : dsum_r[a][c];
        eabs_nxt[a][c] = ddif_r[a][c][ACC_W-1] ? -ddif_r[a][c] : ddif_r[a][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      p_r    <= p_nxt;
      q_r    <= q_nxt;
      dabs_r <= dabs_nxt;
      eabs_r <= eabs_nxt;
    end
  end

  // Stage 5: the box is outside a plane when even its best corner lies outside.
  always_comb begin
    visible_nxt = 1'b1;
    for (int a = 0; a < 3; a++) begin
      below_sum[a] = p_r[a] + dabs_r[a][0] + dabs_r[a][1] + dabs_r[a][2];
      above_sum[a] = q_r[a] + eabs_r[a][0] + eabs_r[a][1] + eabs_r[a][2];
      if (below_sum[a][ACC_W-1] || above_sum[a][ACC_W-1]) begin
        visible_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv5) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      visible_r <= visible_nxt;
    end
  end

  a_stall_needs_box: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && s1_kind_r == KIND_BOX))
    else $error("Input stalled without a box held in stage 1.");

  a_load_makes_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && s1_kind_r == KIND_LOAD && adv2) |=> !v2_r)
    else $error("A matrix load entered the product stage.");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && adv5) |=> out_valid_r)
    else $error("A box leaving stage 4 produced no result.");

endmodule

/* tb/aabb_clip_space_cull_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_clip_space_cull_tb
// Streams matrix loads and box requests into the cull block under random
// source gaps and sink back-pressure. Each box request's verdict is predicted
// exactly from the loaded matrix and compared with the block's output.
// ----------------------------------------------------------------------------
module aabb_clip_space_cull_tb;
  import acsc_pkg::*;

  typedef struct {
    logic               kind;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
  } cull_req_t;

  class cull_scoreboard;
    logic signed [31:0] clip_matrix [16];
    bit                 visible_q [$];
    int                 errors;

    function bit box_visible(cull_req_t r);
      logic signed [63:0]  ctr [3];
      logic signed [63:0]  hal [3];
      logic signed [63:0]  vtx [4];
      logic signed [127:0] clip [4];
      logic signed [127:0] m_wide;
      logic signed [127:0] v_wide;
      bit                  below [3];
      bit                  above [3];
      bit                  vis;
      ctr[0] = 64'(r.center_x);
      ctr[1] = 64'(r.center_y);
      ctr[2] = 64'(r.center_z);
      hal[0] = 64'(r.half_x);
      hal[1] = 64'(r.half_y);
      hal[2] = 64'(r.half_z);
      for (int a = 0; a < 3; a++) begin
        below[a] = 1'b1;
        above[a] = 1'b1;
      end
      for (int k = 0; k < 8; k++) begin
        vtx[0] = (k & 4) != 0 ? ctr[0] + hal[0] : ctr[0] - hal[0];
        vtx[1] = (k & 2) != 0 ? ctr[1] + hal[1] : ctr[1] - hal[1];
        vtx[2] = (k & 1) != 0 ? ctr[2] + hal[2] : ctr[2] - hal[2];
        vtx[3] = 64'sd1 <<< FRAC_BITS;
        for (int row = 0; row < 4; row++) begin
          clip[row] = '0;
          for (int c = 0; c < 4; c++) begin
            m_wide    = 128'(clip_matrix[4'(row * 4 + c)]);
            v_wide    = 128'(vtx[c]);
            clip[row] = clip[row] + m_wide * v_wide;
          end
        end
        for (int a = 0; a < 3; a++) begin
          if (clip[a] + clip[3] >= 0) below[a] = 1'b0;
          if (clip[3] - clip[a] >= 0) above[a] = 1'b0;
        end
      end
      vis = 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (below[a] || above[a]) vis = 1'b0;
      end
      return vis;
    endfunction

    function void note_request(cull_req_t r);
      if (r.kind == KIND_LOAD) begin
        clip_matrix[r.elem_index] = r.elem_value;
      end else begin
        visible_q.push_back(box_visible(r));
      end
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic got);
      bit want;
      if (visible_q.size() == 0) begin
        report($sformatf("result visible=%b with no request outstanding", got));
      end else begin
        want = visible_q.pop_front();
        if (got !== want) begin
          report($sformatf("visible mismatch: got %b, expected %b", got, want));
        end
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_kind;
  logic [3:0]         in_elem_index;
  logic signed [31:0] in_elem_value;
  logic signed [31:0] in_center_x;
  logic signed [31:0] in_center_y;
  logic signed [31:0] in_center_z;
  logic [30:0]        in_half_x;
  logic [30:0]        in_half_y;
  logic [30:0]        in_half_z;
  logic               out_valid;
  logic               out_stall;
  logic               out_visible;

  cull_scoreboard sb;
  int             items_sent;
  bit             hold_request;
  bit             sender_quiet;

  aabb_clip_space_cull uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_elem_index (in_elem_index),
    .in_elem_value (in_elem_value),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_center_z   (in_center_z),
    .in_half_x     (in_half_x),
    .in_half_y     (in_half_y),
    .in_half_z     (in_half_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_visible   (out_visible)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL aabb_clip_space_cull");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [31:0] rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic signed [31:0] rand_full();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rand_half_full();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic cull_req_t make_load(int idx, logic signed [31:0] val);
    cull_req_t r;
    r.kind       = KIND_LOAD;
    r.elem_index = idx[3:0];
    r.elem_value = val;
    r.center_x   = $urandom();
    r.center_y   = $urandom();
    r.center_z   = $urandom();
    r.half_x     = 31'($urandom());
    r.half_y     = 31'($urandom());
    r.half_z     = 31'($urandom());
    return r;
  endfunction

  function automatic cull_req_t make_box(logic signed [31:0] cx, logic signed [31:0] cy,
                                         logic signed [31:0] cz, logic [30:0] hx,
                                         logic [30:0] hy, logic [30:0] hz);
    cull_req_t r;
    r.kind       = KIND_BOX;
    r.elem_index = 4'($urandom());
    r.elem_value = $urandom();
    r.center_x   = cx;
    r.center_y   = cy;
    r.center_z   = cz;
    r.half_x     = hx;
    r.half_y     = hy;
    r.half_z     = hz;
    return r;
  endfunction

  function automatic cull_req_t random_box();
    if ($urandom_range(0, 9) == 0) begin
      return make_box(rand_full(), rand_full(), rand_full(),
                      rand_half_full(), rand_half_full(), rand_half_full());
    end
    return make_box(rand_between(-(4 << 16), 4 << 16), rand_between(-(4 << 16), 4 << 16),
                    rand_between(-(4 << 16), 4 << 16), 31'($urandom_range(0, 2 << 16)),
                    31'($urandom_range(0, 2 << 16)), 31'($urandom_range(0, 2 << 16)));
  endfunction

  function automatic logic signed [31:0] matrix_value(int style, int idx, bit persp);
    int row;
    int col;
    row = idx / 4;
    col = idx % 4;
    if (style == 1) return rand_between(-(1 << 18), 1 << 18);
    if (style == 2) return rand_full();
    if (row == 3) begin
      if (persp) return col == 2 ? -(1 << 16) : 0;
      return col == 3 ? (1 << 16) : 0;
    end
    if (row == col) return rand_between(1 << 14, 1 << 17);
    if (col == 3) return rand_between(-(1 << 17), 1 << 17);
    return rand_between(-(1 << 14), 1 << 14);
  endfunction

  task automatic send_request(cull_req_t r);
    @(negedge clk);
    in_kind       = r.kind;
    in_elem_index = r.elem_index;
    in_elem_value = r.elem_value;
    in_center_x   = r.center_x;
    in_center_y   = r.center_y;
    in_center_z   = r.center_z;
    in_half_x     = r.half_x;
    in_half_y     = r.half_y;
    in_half_z     = r.half_z;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    items_sent++;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic send_paced(cull_req_t r);
    send_request(r);
    if (!sender_quiet) idle_cycles(pick_gap());
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (sb.visible_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_matrix(int style);
    bit persp;
    persp = 1'($urandom_range(0, 1));
    for (int i = 0; i < 16; i++) send_paced(make_load(i, matrix_value(style, i, persp)));
  endtask

  // Sink side: random back-pressure, quiet stretches and one long hold-off.
  initial begin
    int  hold_left;
    int  stall_left;
    int  cycle_count;
    bit  quiet;
    hold_left   = 0;
    stall_left  = 0;
    cycle_count = 0;
    quiet       = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_visible);
      @(negedge clk);
      cycle_count++;
      if (cycle_count % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 120;
      end
      if (hold_left == 0 && stall_left == 0 && !quiet) stall_left = pick_gap();
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    int  style;
    int  n_boxes;
    int  choice;
    bit  pressure_done;
    bit  drain_done;
    sb            = new();
    items_sent    = 0;
    hold_request  = 1'b0;
    sender_quiet  = 1'b0;
    pressure_done = 1'b0;
    drain_done    = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_LOAD;
    in_elem_index = '0;
    in_elem_value = '0;
    in_center_x   = '0;
    in_center_y   = '0;
    in_center_z   = '0;
    in_half_x     = '0;
    in_half_y     = '0;
    in_half_z     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A zero matrix puts every corner on every plane, which counts as inside.
    for (int i = 0; i < 16; i++) send_paced(make_load(i, 0));
    send_paced(make_box(32'sh7FFF_FFFF, 32'sh8000_0000, 0, '1, '0, 31'd1));
    for (int i = 0; i < 16; i += 5) send_paced(make_load(i, 1 << 16));
    send_paced(make_box(0, 0, 0, 31'd32768, 31'd32768, 31'd32768));
    send_paced(make_box(3 << 16, 0, 0, 31'd32768, 31'd32768, 31'd32768));
    send_paced(make_box(-(3 << 16), 0, 0, 31'd32768, 31'd32768, 31'd32768));
    send_paced(make_box(0, 0, 1 << 16, '0, '0, '0));
    send_paced(make_box(0, -(1 << 16), 0, '0, '0, '0));

    while (items_sent < 1850) begin
      sender_quiet = ($urandom_range(0, 5) == 0);
      choice       = $urandom_range(0, 9);
      style        = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
      n_boxes      = $urandom_range(5, 40);
      if (choice < 5) begin
        load_matrix(style);
      end else if (choice < 8) begin
        repeat ($urandom_range(1, 4)) begin
          send_paced(make_load($urandom_range(0, 15), matrix_value(style,
                               $urandom_range(0, 15), 1'($urandom_range(0, 1)))));
        end
      end
      repeat (n_boxes) begin
        if ($urandom_range(0, 19) == 0) begin
          send_paced(make_load($urandom_range(0, 15), rand_full()));
        end else begin
          send_paced(random_box());
        end
      end
      if (!pressure_done && items_sent > 600) begin
        pressure_done = 1'b1;
        idle_cycles(1);
        hold_request = 1'b1;
        repeat (40) send_request(random_box());
      end
      if (!drain_done && items_sent > 1200) begin
        drain_done = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.visible_q.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.visible_q.size()));
    end
    if (sb.errors == 0) begin
      $display("PASS aabb_clip_space_cull");
    end else begin
      $display("FAIL aabb_clip_space_cull");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/acsc_pkg.sv
rtl/aabb_clip_space_cull.sv
tb/aabb_clip_space_cull_tb.sv
